FILE: rtl/satq_pkg.sv
// Package for the sorted alarm timer queue: sizes, codes and item structs.
// No dependencies; used by sorted_alarm_timer_queue, satq_checker and the testbench.
package satq_pkg;

	localparam int ALARM_SLOTS  = 16;
	localparam int HANDLER_BITS = 16;

	// stored handler width: ids at the port are 16 bits
	localparam int HDL_W = (HANDLER_BITS < 16) ? HANDLER_BITS : 16;
	localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam int CNT_W = $clog2(ALARM_SLOTS + 1);

	typedef enum logic [1:0] {
		MODE_STEP    = 2'd0,
		MODE_ABS     = 2'd1,
		MODE_REL     = 2'd2,
		MODE_UNKNOWN = 2'd3
	} mode_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_PAST    = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRED  = 1'b1;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] amount;
		logic [15:0] handler_id;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [31:0] fired_time;
		logic [15:0] fired_handler;
		logic [31:0] time_now;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0]      due;
		logic [HDL_W-1:0] handler;
	} entry_t;

endpackage

FILE: rtl/sorted_alarm_timer_queue.sv
// Top level of the sorted alarm timer queue: sequencer, alarm memory, one comparator.
// Depends on satq_pkg.
//
//  channel   | ports                | handshake
//  ----------+----------------------+-------------------------------------------
//  command   | start, busy, cmd     | item taken at a clock edge with start & !busy
//  result    | rsp_stb, rsp         | item shown for one cycle while rsp_stb is high
//
// A rejected set or an unknown mode is answered at once, from the idle state.
// A step reads and compares the alarms from the head, one memory read and one
// compare per alarm, and stops at the first alarm not yet due or when the table
// is empty. A set moves later entries up one slot, from the tail back; each
// move is a registered memory read followed by a compare and a write. The scan
// stops on an entry due at or before the new alarm or when none is left.
// Reset clears time, count and ring head; the alarm memory itself is not cleared.
// The receiver cannot stall: each result is strobed for exactly one cycle.
module sorted_alarm_timer_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  satq_pkg::cmd_t  cmd,
	output logic            rsp_stb,
	output satq_pkg::rsp_t  rsp
);

	localparam int SLOTS = satq_pkg::ALARM_SLOTS;
	localparam int IDX_W = satq_pkg::IDX_W;
	localparam int CNT_W = satq_pkg::CNT_W;
	localparam int HDL_W = satq_pkg::HDL_W;
	localparam int SUM_W = CNT_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRE,
		S_FIRE_CMP,
		S_INS,
		S_INS_CMP,
		S_FIN
	} state_t;

	// ring index helpers (depth need not be a power of two)
	function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(SLOTS - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] prv(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(SLOTS - 1) : i - 1'b1;
	endfunction

	state_t                state_q;
	satq_pkg::mode_t       mode_q;
	logic [31:0]           cur_q;     // current time
	logic [31:0]           tgt_q;     // new time for a step, due time for a set
	logic [HDL_W-1:0]      hdl_q;
	logic [IDX_W-1:0]      head_q;    // ring slot of the earliest alarm
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      rem_q;     // entries still to compare during insert
	logic [IDX_W-1:0]      wp_q;      // free slot the next write fills
	logic [IDX_W-1:0]      rp_q;      // slot being compared during insert
	logic [1:0]            status_q;
	logic                  stb_q;
	satq_pkg::rsp_t        rsp_q;

	// alarm memory, one write and one registered read per cycle
	satq_pkg::entry_t      mem [SLOTS];
	satq_pkg::entry_t      rd_q;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	satq_pkg::entry_t      wr_data;

	// datapath: one time adder, one shared compare
	logic [31:0]           sum;
	logic [31:0]           cmp_a;
	logic [31:0]           cmp_b;
	logic                  le;
	logic [SUM_W-1:0]      tail_raw;
	logic [IDX_W-1:0]      tail;
	logic                  full;
	logic [31:0]           fin_time;
	logic [1:0]            acc_st;    // status known at accept; not OK answers at once

	assign sum      = cur_q + cmd.amount;
	assign full     = (cnt_q == CNT_W'(SLOTS));
	assign tail_raw = SUM_W'(head_q) + SUM_W'(cnt_q);
	assign tail     = (tail_raw >= SUM_W'(SLOTS)) ? IDX_W'(tail_raw - SUM_W'(SLOTS))
	                                              : IDX_W'(tail_raw);
	assign fin_time = (mode_q == satq_pkg::MODE_STEP) ? tgt_q : cur_q;

	always_comb begin
		if (state_q == S_IDLE) begin
			cmp_a = cmd.amount;
			cmp_b = cur_q;
		end else begin
			cmp_a = rd_q.due;
			cmp_b = tgt_q;
		end
	end
	assign le = (cmp_a <= cmp_b);

	// past check comes before the full check
	always_comb begin
		case (cmd.mode)
			satq_pkg::MODE_STEP: acc_st = satq_pkg::ST_OK;
			satq_pkg::MODE_ABS:  acc_st = le ? satq_pkg::ST_PAST :
			                              (full ? satq_pkg::ST_FULL : satq_pkg::ST_OK);
			satq_pkg::MODE_REL:  acc_st = full ? satq_pkg::ST_FULL : satq_pkg::ST_OK;
			default:             acc_st = satq_pkg::ST_UNKNOWN;
		endcase
	end

	always_comb begin
		case (state_q)
			S_FIRE:     rd_addr = head_q;
			S_FIRE_CMP: rd_addr = nxt(head_q);   // prefetch the following alarm
			S_INS:      rd_addr = rp_q;
			default:    rd_addr = head_q;
		endcase
	end

	// insert writes: the new entry when its place is found, else move one up
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wp_q;
		wr_data = '{due: tgt_q, handler: hdl_q};
		case (state_q)
			S_INS: begin
				wr_en = (rem_q == '0);
			end
			S_INS_CMP: begin
				wr_en = 1'b1;
				if (!le) begin
					wr_data = rd_q;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= satq_pkg::MODE_STEP;
			cur_q    <= '0;
			tgt_q    <= '0;
			hdl_q    <= '0;
			head_q   <= '0;
			cnt_q    <= '0;
			rem_q    <= '0;
			wp_q     <= '0;
			rp_q     <= '0;
			stb_q    <= 1'b0;
			status_q <= satq_pkg::ST_OK;
			rsp_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// status-only answers go straight out
					stb_q <= start && (acc_st != satq_pkg::ST_OK);
					if (start) begin
						mode_q   <= cmd.mode;
						hdl_q    <= cmd.handler_id[HDL_W-1:0];
						status_q <= satq_pkg::ST_OK;
						wp_q     <= tail;
						rp_q     <= prv(tail);
						rem_q    <= cnt_q;
						tgt_q    <= (cmd.mode == satq_pkg::MODE_ABS) ? cmd.amount : sum;
						rsp_q <= '{kind: satq_pkg::KIND_STATUS, status: acc_st,
						          fired_time: '0, fired_handler: '0,
						          time_now: cur_q, last: 1'b1};
						case (cmd.mode)
							satq_pkg::MODE_STEP: begin
								state_q <= S_FIRE;
							end
							satq_pkg::MODE_ABS, satq_pkg::MODE_REL: begin
								if (acc_st == satq_pkg::ST_OK) begin
									state_q <= S_INS;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_FIRE: begin
					stb_q   <= 1'b0;
					state_q <= (cnt_q == '0) ? S_FIN : S_FIRE_CMP;
				end
				S_FIRE_CMP: begin
					stb_q <= le;
					if (le) begin
						rsp_q <= '{kind: satq_pkg::KIND_FIRED, status: satq_pkg::ST_OK,
						          fired_time: rd_q.due, fired_handler: 16'(rd_q.handler),
						          time_now: rd_q.due, last: 1'b0};
						cur_q  <= rd_q.due;
						head_q <= nxt(head_q);
						cnt_q  <= cnt_q - 1'b1;
						if (cnt_q == CNT_W'(1)) begin
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_FIN;
					end
				end
				S_INS: begin
					stb_q <= 1'b0;
					if (rem_q == '0) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					stb_q <= 1'b0;
					if (!le) begin
						// later alarm moves up one slot
						wp_q    <= rp_q;
						rp_q    <= prv(rp_q);
						rem_q   <= rem_q - 1'b1;
						state_q <= S_INS;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					rsp_q <= '{kind: satq_pkg::KIND_STATUS, status: status_q,
					          fired_time: '0, fired_handler: '0,
					          time_now: fin_time, last: 1'b1};
					stb_q   <= 1'b1;
					cur_q   <= fin_time;
					state_q <= S_IDLE;
				end
				default: begin
					stb_q   <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign rsp_stb = stb_q;
	assign rsp     = rsp_q;

	// the table never holds more alarms than slots
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SLOTS))
		else $error("alarm count beyond table size");

	// an accepted item either keeps the block busy or is answered at once
	a_accept_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || (rsp_stb && rsp.last)))
		else $error("item accepted without work or answer");

	// the closing result of an item is always a status result
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_stb && rsp.last) |-> (rsp.kind == satq_pkg::KIND_STATUS))
		else $error("last result is not a status result");

	// a fired alarm moves time to its due time, and comes out while busy
	a_fired_time: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_stb && rsp.kind == satq_pkg::KIND_FIRED) |->
		(rsp.time_now == rsp.fired_time && busy))
		else $error("fired report inconsistent");

endmodule

FILE: test/satq_checker.sv
// Checker for the sorted alarm timer queue: watches the command and result channels,
// predicts each item's results and compares them. Depends on satq_pkg.
module satq_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  satq_pkg::cmd_t   cmd,
	input  logic             rsp_stb,
	input  satq_pkg::rsp_t   rsp,
	output int               failures,
	output int               pending,
	output int               results_seen,
	output int               fired_seen
);
	import satq_pkg::*;

	// predicted block state
	logic [31:0]      now_time;
	logic [31:0]      slot_due [ALARM_SLOTS];
	logic [HDL_W-1:0] slot_hdl [ALARM_SLOTS];
	int               slot_cnt;

	rsp_t             due_rsp[$];
	int               mism;
	int               n_res;
	int               n_fired;

	// sorted insert; equal due times go after existing ones
	function automatic logic [1:0] store_alarm(input logic [31:0] due, input logic [15:0] hid);
		int pos;
		if (slot_cnt >= ALARM_SLOTS)
			return ST_FULL;
		pos = 0;
		while (pos < slot_cnt && slot_due[pos] <= due)
			pos++;
		for (int i = slot_cnt; i > pos; i--) begin
			slot_due[i] = slot_due[i-1];
			slot_hdl[i] = slot_hdl[i-1];
		end
		slot_due[pos] = due;
		slot_hdl[pos] = hid[HDL_W-1:0];
		slot_cnt++;
		return ST_OK;
	endfunction

	task automatic predict_cmd(input cmd_t c);
		rsp_t        r;
		logic [31:0] t_new;
		logic [1:0]  st;
		int          fired;
		st = ST_OK;
		case (c.mode)
			MODE_STEP: begin
				t_new = now_time + c.amount;
				fired = 0;
				while (fired < slot_cnt && slot_due[fired] <= t_new) begin
					r               = '0;
					r.kind          = KIND_FIRED;
					r.fired_time    = slot_due[fired];
					r.fired_handler = 16'(slot_hdl[fired]);
					r.time_now      = slot_due[fired];
					due_rsp.push_back(r);
					fired++;
				end
				for (int i = 0; i + fired < slot_cnt; i++) begin
					slot_due[i] = slot_due[i+fired];
					slot_hdl[i] = slot_hdl[i+fired];
				end
				slot_cnt -= fired;
				now_time = t_new;
			end
			MODE_ABS: begin
				if (c.amount <= now_time)
					st = ST_PAST;
				else
					st = store_alarm(c.amount, c.handler_id);
			end
			MODE_REL: st = store_alarm(now_time + c.amount, c.handler_id);
			default:  st = ST_UNKNOWN;
		endcase
		r          = '0;
		r.kind     = KIND_STATUS;
		r.status   = st;
		r.time_now = now_time;
		r.last     = 1'b1;
		due_rsp.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_time = '0;
			slot_cnt = 0;
			mism     = 0;
			n_res    = 0;
			n_fired  = 0;
			due_rsp.delete();
			failures     <= 0;
			pending      <= 0;
			results_seen <= 0;
			fired_seen   <= 0;
		end else begin
			// results first: one strobed now belongs to an earlier item
			if (rsp_stb) begin
				n_res++;
				if (rsp.kind == KIND_FIRED)
					n_fired++;
				if (due_rsp.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("unexpected result: kind=%0d st=%0d ft=%h fh=%h now=%h last=%0d",
							rsp.kind, rsp.status, rsp.fired_time, rsp.fired_handler,
							rsp.time_now, rsp.last);
				end else begin
					rsp_t e;
					e = due_rsp.pop_front();
					if (rsp.kind !== e.kind || rsp.status !== e.status ||
					    rsp.fired_time !== e.fired_time ||
					    rsp.fired_handler !== e.fired_handler ||
					    rsp.time_now !== e.time_now || rsp.last !== e.last) begin
						mism++;
						if (mism <= 10) begin
							$display("result mismatch at %0t:", $realtime);
							$display("  exp kind=%0d st=%0d ft=%h fh=%h now=%h last=%0d",
								e.kind, e.status, e.fired_time, e.fired_handler,
								e.time_now, e.last);
							$display("  got kind=%0d st=%0d ft=%h fh=%h now=%h last=%0d",
								rsp.kind, rsp.status, rsp.fired_time, rsp.fired_handler,
								rsp.time_now, rsp.last);
						end
					end
				end
			end
			if (start && !busy)
				predict_cmd(cmd);
			failures     <= mism;
			pending      <= due_rsp.size();
			results_seen <= n_res;
			fired_seen   <= n_fired;
		end
	end

endmodule

FILE: test/tb_sorted_alarm_timer_queue.sv
// Testbench top for the sorted alarm timer queue: clock, reset, command stimulus, verdict.
// Depends on satq_pkg, sorted_alarm_timer_queue and satq_checker.
module tb_sorted_alarm_timer_queue;
	import satq_pkg::*;

	localparam int LIMIT = 200000;	// cycles

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	cmd_t  cmd;
	logic  rsp_stb;
	rsp_t  rsp;

	int    failures;
	int    pending;
	int    results_seen;
	int    fired_seen;
	int    sent;
	int    cycles;
	bit    calm;		// no idle gaps between items while set
	logic [31:0] seen_time;	// time from the last status result, used to aim absolute sets

	sorted_alarm_timer_queue dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.rsp_stb (rsp_stb),
		.rsp     (rsp)
	);

	satq_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.rsp_stb      (rsp_stb),
		.rsp          (rsp),
		.failures     (failures),
		.pending      (pending),
		.results_seen (results_seen),
		.fired_seen   (fired_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// the block's notion of time, as it reports it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_time <= '0;
		end else if (rsp_stb && rsp.last) begin
			seen_time <= rsp.time_now;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Drive one item from a falling edge and hold it until taken. Start stays
	// high into the next falling edge; it drops there only if a gap follows,
	// so back-to-back items never toggle it within one step.
	task automatic send_cmd(input mode_t m, input logic [31:0] amt, input logic [15:0] hid);
		int gap;
		start          = 1'b1;
		cmd.mode       = m;
		cmd.amount     = amt;
		cmd.handler_id = hid;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		sent++;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// One random item. set_pct biases toward filling the table (high) or
	// draining it with steps (low). Deltas stay small most of the time so
	// alarms actually come due; full-range values keep every bit moving.
	task automatic random_cmd(input int set_pct);
		int          r;
		int          sub;
		logic [31:0] amt;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			send_cmd(MODE_UNKNOWN, $urandom, 16'($urandom));
		end else if (r < 5 + set_pct) begin
			sub = $urandom_range(0, 9);
			if (sub < 5)
				send_cmd(MODE_REL, $urandom_range(0, 300), 16'($urandom));
			else if (sub < 6)
				send_cmd(MODE_REL, $urandom, 16'($urandom));
			else if (sub < 9) begin
				// near the current time: some land in the past
				amt = seen_time + $urandom_range(0, 300) - 32'd30;
				send_cmd(MODE_ABS, amt, 16'($urandom));
			end else
				send_cmd(MODE_ABS, $urandom, 16'($urandom));
		end else begin
			sub = $urandom_range(0, 99);
			if (sub < 70)
				amt = $urandom_range(0, 120);
			else if (sub < 88)
				amt = $urandom_range(0, 3);
			else if (sub < 97)
				amt = $urandom_range(200, 2000);
			else
				amt = $urandom;
			send_cmd(MODE_STEP, amt, 16'($urandom));
		end
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		sent      = 0;
		cycles    = 0;
		calm      = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed ---
		send_cmd(MODE_STEP, 32'd0, 16'h0000);		// empty step
		send_cmd(MODE_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF);	// unknown mode
		send_cmd(MODE_ABS, 32'd0, 16'h5555);		// absolute at now: past
		send_cmd(MODE_ABS, 32'd100, 16'hFFFF);		// equal due times keep
		send_cmd(MODE_ABS, 32'd100, 16'h0000);		//   insertion order
		send_cmd(MODE_REL, 32'd50, 16'h1234);
		send_cmd(MODE_REL, 32'd0, 16'hAAAA);		// due right now
		send_cmd(MODE_ABS, 32'hFFFF_FFFF, 16'h8001);	// latest possible due
		send_cmd(MODE_STEP, 32'd0, 16'hFFFF);		// zero step fires the due-now one
		send_cmd(MODE_STEP, 32'd100, 16'h0000);		// fires 50, 100, 100
		send_cmd(MODE_REL, 32'hFFFF_FFFF, 16'h7FFE);	// wraps to 99, behind now
		send_cmd(MODE_STEP, 32'd0, 16'h0001);		// fires the wrapped one
		// fill the table, with repeated due times mixed in
		for (int i = 0; i < 15; i++)
			send_cmd(MODE_REL, 32'((i % 5) * 40 + 10), 16'($urandom));
		send_cmd(MODE_REL, 32'd5, 16'h00FF);		// table full
		send_cmd(MODE_ABS, 32'd5, 16'hFF00);		// past wins over full
		send_cmd(MODE_STEP, 32'hFFFF_FFFF, 16'h0000);	// time wraps to 99, nothing due
		send_cmd(MODE_STEP, 32'hFFFF_FFFF - 32'd99, 16'hFFFF);	// to max: all 16 fire

		// --- random: alternate fill and drain phases, two of them without gaps ---
		for (int rnd = 0; rnd < 10; rnd++) begin
			calm = (rnd == 3 || rnd == 7);
			for (int k = 0; k < 38; k++)
				random_cmd((rnd % 2 == 0) ? 75 : 30);
		end
		calm = 1'b0;
		start = 1'b0;

		// drain, then let the block settle
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d commands (steps, absolute and relative sets, unknown modes).", sent);
		$display("Checked %0d results, %0d of them fired alarms.", results_seen, fired_seen);
		if (failures == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
